// ===== hw/rtl/qrm_pkg.sv =====
// Package for the quaternion to rotation matrix block.
// Holds the field widths, the default fraction width and the payload structs.
// Used by the top level and its checker; depends on nothing.
package qrm_pkg;

  localparam int FRAC_BITS_DEF = 14;
  localparam int COMP_W        = 16;
  localparam int NUM_ELEM      = 9;

  typedef struct packed {
    logic signed [COMP_W-1:0] quat_x;
    logic signed [COMP_W-1:0] quat_y;
    logic signed [COMP_W-1:0] quat_z;
    logic signed [COMP_W-1:0] quat_w;
  } quat_t;

  typedef struct packed {
    logic signed [COMP_W-1:0] rot_r1c1;
    logic signed [COMP_W-1:0] rot_r1c2;
    logic signed [COMP_W-1:0] rot_r1c3;
    logic signed [COMP_W-1:0] rot_r2c1;
    logic signed [COMP_W-1:0] rot_r2c2;
    logic signed [COMP_W-1:0] rot_r2c3;
    logic signed [COMP_W-1:0] rot_r3c1;
    logic signed [COMP_W-1:0] rot_r3c2;
    logic signed [COMP_W-1:0] rot_r3c3;
    logic                     degenerate;
  } rot_t;

endpackage

// ===== hw/rtl/quaternion_to_rotation_matrix.sv =====
// Quaternion to 3x3 rotation matrix, normalized, with rounding and saturation.
// Input channel: in_valid / in_stall / in_data (quat_t, four signed components
// with FRAC_BITS fraction bits). Output channel: out_valid / out_stall /
// out_data (rot_t, nine matrix elements and a degenerate flag).
// Each element is the rounded quotient num * 2^FRAC_BITS / n, where n is the
// squared length, computed by a restoring divider that resolves one quotient
// bit per pipeline stage in nine parallel lanes.
// The stages are one of products, one of sums, one of sign and magnitude,
// FRAC_BITS + 2 divider stages and one of rounding and saturation into the
// output register. Throughput is one transaction per cycle while no result
// waits under out_stall; the divider depth sets the latency.
// A zero-length quaternion gives the identity matrix with degenerate set.
// Reset empties the pipeline. While out_stall holds a waiting result, the
// whole pipeline freezes and in_stall is raised; nothing is lost or repeated,
// and the output payload stays unchanged until it is taken.
module quaternion_to_rotation_matrix #(
  parameter int FRAC_BITS = qrm_pkg::FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  qrm_pkg::quat_t in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output qrm_pkg::rot_t out_data
);

  localparam int NE     = qrm_pkg::NUM_ELEM;
  localparam int CW     = qrm_pkg::COMP_W;
  localparam int PW     = 2 * CW;          // product width
  localparam int NW     = PW + 1;          // squared length width
  localparam int SW     = PW + 3;          // signed numerator width
  localparam int RW     = PW + 2;          // divider remainder width
  localparam int DIV_N  = FRAC_BITS + 2;   // quotient bits incl. rounding bit
  localparam int QW     = DIV_N;
  localparam longint ONE    = longint'(1) << FRAC_BITS;
  localparam longint HI_MAG = (ONE < 32767) ? ONE : 32767;
  localparam longint LO_MAG = (ONE < 32768) ? ONE : 32768;

  logic adv;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // Stage 0: the ten products.
  logic                 v0_r;
  logic signed [PW-1:0] xx_r, yy_r, zz_r, ww_r, xy_r, xz_r, xw_r, yz_r, yw_r, zw_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (adv) begin
      v0_r <= in_valid;
    end
    if (adv) begin
      xx_r <= in_data.quat_x * in_data.quat_x;
      yy_r <= in_data.quat_y * in_data.quat_y;
      zz_r <= in_data.quat_z * in_data.quat_z;
      ww_r <= in_data.quat_w * in_data.quat_w;
      xy_r <= in_data.quat_x * in_data.quat_y;
      xz_r <= in_data.quat_x * in_data.quat_z;
      xw_r <= in_data.quat_x * in_data.quat_w;
      yz_r <= in_data.quat_y * in_data.quat_z;
      yw_r <= in_data.quat_y * in_data.quat_w;
      zw_r <= in_data.quat_z * in_data.quat_w;
    end
  end

  // Stage 1: squared length and the nine numerators.
  logic                 v1_r;
  logic [NW-1:0]        n1_r;
  logic signed [SW-1:0] num1_r [NE];

  logic signed [SW-1:0] sxx, syy, szz, sww, sxy, sxz, sxw, syz, syw, szw;
  always_comb begin
    sxx = SW'(xx_r); syy = SW'(yy_r); szz = SW'(zz_r); sww = SW'(ww_r);
    sxy = SW'(xy_r); sxz = SW'(xz_r); sxw = SW'(xw_r);
    syz = SW'(yz_r); syw = SW'(yw_r); szw = SW'(zw_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= v0_r;
    end
    if (adv) begin
      n1_r      <= NW'(sxx + syy + szz + sww);
      num1_r[0] <= sxx + sww - syy - szz;
      num1_r[1] <= (sxy - szw) <<< 1;
      num1_r[2] <= (sxz + syw) <<< 1;
      num1_r[3] <= (sxy + szw) <<< 1;
      num1_r[4] <= syy + sww - sxx - szz;
      num1_r[5] <= (syz - sxw) <<< 1;
      num1_r[6] <= (sxz - syw) <<< 1;
      num1_r[7] <= (syz + sxw) <<< 1;
      num1_r[8] <= szz + sww - sxx - syy;
    end
  end

  // Stage 2 onward: divider. Index 0 holds sign and clamped magnitude,
  // index k+1 holds the state after quotient bit k.
  logic          vd_r  [DIV_N+1];
  logic [NW-1:0] nd_r  [DIV_N+1];
  logic [RW-1:0] rem_r [DIV_N+1][NE];
  logic [QW-1:0] q_r   [DIV_N+1][NE];
  logic          neg_r [DIV_N+1][NE];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r[0] <= 1'b0;
    end else if (adv) begin
      vd_r[0] <= v1_r;
    end
    if (adv) begin
      nd_r[0] <= n1_r;
    end
  end

  for (genvar e = 0; e < NE; e++) begin : g_init
    logic [SW-1:0] mag;
    always_comb begin
      mag = num1_r[e][SW-1] ? SW'(-num1_r[e]) : SW'(num1_r[e]);
      if (mag > SW'(n1_r)) begin
        mag = SW'(n1_r);
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[0][e] <= RW'(mag);
        q_r[0][e]   <= '0;
        neg_r[0][e] <= num1_r[e][SW-1];
      end
    end
  end

  for (genvar k = 0; k < DIV_N; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vd_r[k+1] <= 1'b0;
      end else if (adv) begin
        vd_r[k+1] <= vd_r[k];
      end
      if (adv) begin
        nd_r[k+1] <= nd_r[k];
      end
    end
    for (genvar e = 0; e < NE; e++) begin : g_lane
      logic [RW-1:0] t;
      logic          bit_q;
      always_comb begin
        t     = (k == 0) ? rem_r[k][e] : (rem_r[k][e] << 1);
        bit_q = t >= RW'(nd_r[k]);
      end
      always_ff @(posedge clk) begin
        if (adv) begin
          rem_r[k+1][e] <= bit_q ? (t - RW'(nd_r[k])) : t;
          q_r[k+1][e]   <= {q_r[k][e][QW-2:0], bit_q};
          neg_r[k+1][e] <= neg_r[k][e];
        end
      end
    end
  end

  // Final stage: round half away from zero, saturate, identity on zero length.
  logic  out_valid_r;
  qrm_pkg::rot_t out_data_r;
  logic [CW-1:0] elem [NE];
  logic          deg;

  for (genvar e = 0; e < NE; e++) begin : g_out
    logic [31:0] rq;
    logic [31:0] lim;
    always_comb begin
      rq  = (32'(q_r[DIV_N][e]) + 32'd1) >> 1;
      lim = neg_r[DIV_N][e] ? 32'(LO_MAG) : 32'(HI_MAG);
      if (rq > lim) begin
        rq = lim;
      end
      if (deg) begin
        elem[e] = (e % 4 == 0) ? CW'(HI_MAG) : '0;
      end else begin
        elem[e] = neg_r[DIV_N][e] ? CW'(-rq) : CW'(rq);
      end
    end
  end

  assign deg = (nd_r[DIV_N] == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vd_r[DIV_N];
    end
    if (adv) begin
      out_data_r.rot_r1c1   <= elem[0];
      out_data_r.rot_r1c2   <= elem[1];
      out_data_r.rot_r1c3   <= elem[2];
      out_data_r.rot_r2c1   <= elem[3];
      out_data_r.rot_r2c2   <= elem[4];
      out_data_r.rot_r2c3   <= elem[5];
      out_data_r.rot_r3c1   <= elem[6];
      out_data_r.rot_r3c2   <= elem[7];
      out_data_r.rot_r3c3   <= elem[8];
      out_data_r.degenerate <= deg;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== hw/rtl/qrm_checker.sv =====
// Port-level checker for the quaternion to rotation matrix block.
// Depends on qrm_pkg and is bound to the top level at the end of this file.
module qrm_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_stall,
  input qrm_pkg::quat_t in_data,
  input logic           out_valid,
  input logic           out_stall,
  input qrm_pkg::rot_t  out_data
);

  // The input is held off exactly when a finished result is waiting.
  a_stall_rule: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("in_stall does not follow the waiting output");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output transaction changed");

  // A degenerate result has zero off-diagonal elements and equal diagonal elements.
  a_degen_ident: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.degenerate |->
      out_data.rot_r1c2 == '0 && out_data.rot_r1c3 == '0 &&
      out_data.rot_r2c1 == '0 && out_data.rot_r2c3 == '0 &&
      out_data.rot_r3c1 == '0 && out_data.rot_r3c2 == '0 &&
      out_data.rot_r1c1 == out_data.rot_r2c2 &&
      out_data.rot_r2c2 == out_data.rot_r3c3)
    else $error("degenerate result is not the identity");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind quaternion_to_rotation_matrix qrm_checker u_qrm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ===== dv/tb.sv =====
// Testbench for quaternion_to_rotation_matrix: random and directed quaternions,
// checked against a behavioral rotation-matrix predictor with random idling.
// Depends on qrm_pkg and the quaternion_to_rotation_matrix RTL.
`timescale 1ns / 100ps

class rot_scoreboard;
  qrm_pkg::rot_t pending_rot[$];
  int errors;
  int matched;
  int degenerate_seen;

  // Rounded quotient num * 2^14 / n, ties away from zero, clamped to +/- one.
  function automatic logic signed [15:0] quot_q14(longint num, longint n);
    longint mag;
    longint q;
    logic neg;
    neg = num < 0;
    mag = neg ? -num : num;
    if (mag > n) mag = n;
    mag = mag << qrm_pkg::FRAC_BITS_DEF;
    q = (2 * mag + n) / (2 * n);
    if (q > (1 << qrm_pkg::FRAC_BITS_DEF)) q = 1 << qrm_pkg::FRAC_BITS_DEF;
    return neg ? 16'(-q) : 16'(q);
  endfunction

  function void note_quat(qrm_pkg::quat_t q);
    longint x, y, z, w, xx, yy, zz, ww, n;
    qrm_pkg::rot_t r;
    x = q.quat_x; y = q.quat_y; z = q.quat_z; w = q.quat_w;
    xx = x * x; yy = y * y; zz = z * z; ww = w * w;
    n = xx + yy + zz + ww;
    r = '0;
    if (n == 0) begin
      r.rot_r1c1 = 16'sd16384;
      r.rot_r2c2 = 16'sd16384;
      r.rot_r3c3 = 16'sd16384;
      r.degenerate = 1'b1;
    end else begin
      r.rot_r1c1 = quot_q14(n - 2 * (yy + zz), n);
      r.rot_r1c2 = quot_q14(2 * (x * y - z * w), n);
      r.rot_r1c3 = quot_q14(2 * (x * z + y * w), n);
      r.rot_r2c1 = quot_q14(2 * (x * y + z * w), n);
      r.rot_r2c2 = quot_q14(n - 2 * (xx + zz), n);
      r.rot_r2c3 = quot_q14(2 * (y * z - x * w), n);
      r.rot_r3c1 = quot_q14(2 * (x * z - y * w), n);
      r.rot_r3c2 = quot_q14(2 * (y * z + x * w), n);
      r.rot_r3c3 = quot_q14(n - 2 * (xx + yy), n);
    end
    pending_rot.push_back(r);
  endfunction

  function void check_rot(qrm_pkg::rot_t got);
    qrm_pkg::rot_t exp_rot;
    if (pending_rot.size() == 0) begin
      $display("%0t: unexpected result %h", $realtime, got);
      errors++;
      return;
    end
    exp_rot = pending_rot.pop_front();
    if (got.degenerate) degenerate_seen++;
    if (got !== exp_rot) begin
      $display("%0t: mismatch expected %h actual %h", $realtime, exp_rot, got);
      if (got.rot_r1c1 !== exp_rot.rot_r1c1)
        $display("  r1c1 exp %0d act %0d", exp_rot.rot_r1c1, got.rot_r1c1);
      if (got.rot_r1c2 !== exp_rot.rot_r1c2)
        $display("  r1c2 exp %0d act %0d", exp_rot.rot_r1c2, got.rot_r1c2);
      if (got.rot_r1c3 !== exp_rot.rot_r1c3)
        $display("  r1c3 exp %0d act %0d", exp_rot.rot_r1c3, got.rot_r1c3);
      if (got.rot_r2c1 !== exp_rot.rot_r2c1)
        $display("  r2c1 exp %0d act %0d", exp_rot.rot_r2c1, got.rot_r2c1);
      if (got.rot_r2c2 !== exp_rot.rot_r2c2)
        $display("  r2c2 exp %0d act %0d", exp_rot.rot_r2c2, got.rot_r2c2);
      if (got.rot_r2c3 !== exp_rot.rot_r2c3)
        $display("  r2c3 exp %0d act %0d", exp_rot.rot_r2c3, got.rot_r2c3);
      if (got.rot_r3c1 !== exp_rot.rot_r3c1)
        $display("  r3c1 exp %0d act %0d", exp_rot.rot_r3c1, got.rot_r3c1);
      if (got.rot_r3c2 !== exp_rot.rot_r3c2)
        $display("  r3c2 exp %0d act %0d", exp_rot.rot_r3c2, got.rot_r3c2);
      if (got.rot_r3c3 !== exp_rot.rot_r3c3)
        $display("  r3c3 exp %0d act %0d", exp_rot.rot_r3c3, got.rot_r3c3);
      if (got.degenerate !== exp_rot.degenerate)
        $display("  degenerate exp %0b act %0b", exp_rot.degenerate, got.degenerate);
      errors++;
    end else begin
      matched++;
    end
  endfunction
endclass

module tb;
  localparam int NUM_RANDOM = 1930;
  localparam int LATENCY = qrm_pkg::FRAC_BITS_DEF + 6;
  localparam int IDLE_LIMIT = 5000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  qrm_pkg::quat_t in_data;
  logic out_valid;
  logic out_stall;
  qrm_pkg::rot_t out_data;

  rot_scoreboard sb;
  logic sending_done;
  logic calm_phase;
  int quats_sent;
  int idle_cycles;

  quaternion_to_rotation_matrix DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    sending_done = 1'b0;
    calm_phase = 1'b0;
    quats_sent = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Components drawn mostly from corners and small values, sometimes full range.
  function automatic logic [15:0] pick_comp();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'($urandom_range(0, 3) - 2);
      4: return 16'h4000;
      default: return 16'($urandom());
    endcase
  endfunction

  // Offers one quaternion and holds it until it is taken.
  task automatic send_quat(logic [15:0] x, logic [15:0] y, logic [15:0] z,
                           logic [15:0] w);
    in_valid <= 1'b1;
    in_data <= {x, y, z, w};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_quat(in_data);
    quats_sent++;
    if (!calm_phase && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      in_data <= {$urandom(), $urandom()};
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  initial begin
    @(posedge clk iff rst_n);
    // Directed: zero length, axes, extremes, sign mix, tiny magnitudes.
    send_quat(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_quat(16'h0000, 16'h0000, 16'h0000, 16'h4000);
    send_quat(16'h4000, 16'h0000, 16'h0000, 16'h0000);
    send_quat(16'h0000, 16'h4000, 16'h0000, 16'h0000);
    send_quat(16'h0000, 16'h0000, 16'h4000, 16'h0000);
    send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_quat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    send_quat(16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
    send_quat(16'h0001, 16'h0000, 16'h0000, 16'h0000);
    send_quat(16'hffff, 16'h0001, 16'hffff, 16'h0001);
    send_quat(16'h2d41, 16'h0000, 16'h0000, 16'h2d41);
    send_quat(16'h0000, 16'h0000, 16'h0000, 16'h8000);
    send_quat(16'h2000, 16'h2000, 16'h2000, 16'h2000);
    send_quat(16'h5555, 16'haaaa, 16'h0f0f, 16'hf0f0);
    send_quat(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_quat(16'h0001, 16'h0001, 16'h0000, 16'h0000);
    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i == NUM_RANDOM - 150) calm_phase <= 1'b1;
      if ($urandom_range(0, 30) == 0) send_quat(16'h0000, 16'h0000, 16'h0000, 16'h0000);
      else send_quat(pick_comp(), pick_comp(), pick_comp(), pick_comp());
    end
    in_valid <= 1'b0;
    sending_done <= 1'b1;
  end

  // Receiver: random stall bursts, one long hold early on to back up the pipe.
  initial begin
    @(posedge clk iff rst_n);
    repeat (40) @(posedge clk);
    out_stall <= 1'b1;
    repeat (80) @(posedge clk);
    out_stall <= 1'b0;
    while (!calm_phase) begin
      repeat ($urandom_range(1, 20)) @(posedge clk);
      if (calm_phase) break;
      out_stall <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_rot(out_data);
  end

  // Watchdog on cycles without any accepted transaction.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb: FAIL");
        $finish;
      end
    end
  end

  initial begin
    @(posedge clk iff sending_done);
    while (sb.pending_rot.size() != 0) @(posedge clk);
    repeat (2 * LATENCY) @(posedge clk);
    $display("Ran %0d quaternions, %0d matrices matched, %0d degenerate, under stalls.",
             quats_sent, sb.matched, sb.degenerate_seen);
    if (sb.errors == 0 && sb.pending_rot.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
hw/rtl/qrm_pkg.sv
hw/rtl/quaternion_to_rotation_matrix.sv
hw/rtl/qrm_checker.sv
dv/tb.sv
